FILE: rtl/core/ordered_list_engine_macros.svh
// Assertion macros shared by the ordered list engine RTL.
// No dependencies.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Implication check, reset-gated.
`define OLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication check, reset-gated.
`define OLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/ole_pkg.sv
// Shared constants and types for the ordered list engine.
// No dependencies.
package ole_pkg;

    localparam int Depth = 16;
    localparam int IdxW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);
    localparam int MaxOut = 16;

    localparam logic [2:0] KIND_INS_HEAD = 3'd0;
    localparam logic [2:0] KIND_INS_TAIL = 3'd1;
    localparam logic [2:0] KIND_DELETE   = 3'd2;
    localparam logic [2:0] KIND_SEARCH   = 3'd3;
    localparam logic [2:0] KIND_SORT     = 3'd4;
    localparam logic [2:0] KIND_REVERSE  = 3'd5;
    localparam logic [2:0] KIND_DUMP_FWD = 3'd6;
    localparam logic [2:0] KIND_DUMP_BWD = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic        we;
        logic [IdxW-1:0] waddr;
        logic [31:0] wdata;
    } mem_wr_t;

endpackage

FILE: rtl/core/ole_ram.sv
// Single write port, single registered read port RAM for list entries.
// Depends on ole_pkg.
module ole_ram
(
    input  logic                    clk,
    input  ole_pkg::mem_wr_t        wr,
    input  logic [ole_pkg::IdxW-1:0] raddr,
    output logic [31:0]             rdata
);

    logic [31:0] mem [ole_pkg::Depth];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.waddr] <= wr.wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/ordered_list_engine.sv
// Ordered list engine: a list of up to ole_pkg::Depth signed 32-bit values kept in one RAM
// with a single read port and a single write port, run by a sequencer.
// The block takes one word at a time and finishes each operation before the next. All work
// goes through the one RAM port pair: read an entry, then write or compare.
// Tail insert, or any insert into an empty list, writes the entry directly. Head insert
// shifts each entry up from the tail, then writes the head. Delete and search scan from
// the head; delete moves later entries down. Reverse swaps pairs from both ends. Sort:
// insertion sort. Read-out waits on output stalls. No clearing pass after reset.
module ordered_list_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic signed [31:0] operand_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        found,
    output logic signed [31:0] entry_value,
    output logic        last,
    output logic [4:0]  entry_count
);

    localparam int IW = ole_pkg::IdxW;
    localparam int CW = ole_pkg::CntW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_EXEC  = 4'd2;
    localparam logic [3:0] S_RD2   = 4'd3;
    localparam logic [3:0] S_EXEC2 = 4'd4;
    localparam logic [3:0] S_WR2   = 4'd5;
    localparam logic [3:0] S_OUT   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_SRD   = 4'd8;
    localparam logic [3:0] S_SCMP  = 4'd9;

    logic [3:0]      state_reg, state_next;
    logic [CW-1:0]   occ_reg, occ_next;
    logic [2:0]      kind_reg, kind_next;
    logic [31:0]     opv_reg, opv_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [31:0]     key_reg, key_next;
    logic [31:0]     tmp_reg, tmp_next;
    logic [4:0]      ocnt_reg, ocnt_next;
    logic            ov_reg, ov_next;
    logic [1:0]      st_reg, st_next;
    logic            fd_reg, fd_next;
    logic [31:0]     ev_reg, ev_next;
    logic            ls_reg, ls_next;

    ole_pkg::mem_wr_t wr;
    logic [IW-1:0]   raddr;
    logic [31:0]     rdata;
    logic            out_free;

    ole_ram u_ram
    (
        .clk   (clk),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign out_free = !ov_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && !ov_reg;

    assign out_valid   = ov_reg;
    assign status      = st_reg;
    assign found       = fd_reg;
    assign entry_value = ev_reg;
    assign last        = ls_reg;
    assign entry_count = ocnt_reg;

    always_comb
    begin
        state_next = state_reg;
        occ_next   = occ_reg;
        kind_next  = kind_reg;
        opv_next   = opv_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        key_next   = key_reg;
        tmp_next   = tmp_reg;
        ov_next    = ov_reg && !out_ready;
        st_next    = st_reg;
        fd_next    = fd_reg;
        ev_next    = ev_reg;
        ls_next    = ls_reg;
        ocnt_next  = ocnt_reg;
        wr         = '0;
        raddr      = i_reg[IW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    kind_next = kind;
                    opv_next  = operand_value;
                    st_next   = ole_pkg::ST_OK;
                    fd_next   = 1'b0;
                    ev_next   = '0;
                    state_next = S_FIN;
                    case (kind) inside
                        ole_pkg::KIND_INS_HEAD, ole_pkg::KIND_INS_TAIL:
                        begin
                            if (occ_reg == CW'(ole_pkg::Depth))
                            begin
                                st_next = ole_pkg::ST_FULL;
                            end
                            else if (kind == ole_pkg::KIND_INS_TAIL || occ_reg == '0)
                            begin
                                wr.we    = 1'b1;
                                wr.waddr = occ_reg[IW-1:0];
                                wr.wdata = operand_value;
                                if (kind == ole_pkg::KIND_INS_HEAD)
                                begin
                                    wr.waddr = '0;
                                end
                                occ_next = occ_reg + 1'b1;
                            end
                            else
                            begin
                                // shift up from tail
                                i_next = occ_reg - 1'b1;
                                state_next = S_RD;
                            end
                        end
                        ole_pkg::KIND_DELETE, ole_pkg::KIND_SEARCH,
                        ole_pkg::KIND_DUMP_FWD, ole_pkg::KIND_DUMP_BWD:
                        begin
                            if (occ_reg == '0)
                            begin
                                st_next = (kind[2]) ? ole_pkg::ST_EMPTY
                                                    : ole_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                i_next = (kind == ole_pkg::KIND_DUMP_BWD) ?
                                         occ_reg - 1'b1 : '0;
                                j_next = '0;
                                state_next = S_RD;
                            end
                        end
                        ole_pkg::KIND_SORT:
                        begin
                            if (occ_reg > CW'(1))
                            begin
                                i_next = CW'(1);
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            if (occ_reg > CW'(1))
                            begin
                                i_next = '0;
                                j_next = occ_reg - 1'b1;
                                state_next = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_RD:
            begin
                raddr = i_reg[IW-1:0];
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (kind_reg)
                    ole_pkg::KIND_INS_HEAD:
                    begin
                        wr.we    = 1'b1;
                        wr.waddr = IW'(i_reg + 1'b1);
                        wr.wdata = rdata;
                        if (i_reg == '0)
                        begin
                            state_next = S_WR2;
                        end
                        else
                        begin
                            i_next = i_reg - 1'b1;
                            state_next = S_RD;
                        end
                    end
                    ole_pkg::KIND_DELETE:
                    begin
                        if (fd_reg)
                        begin
                            wr.we    = 1'b1;
                            wr.waddr = IW'(i_reg - 1'b1);
                            wr.wdata = rdata;
                        end
                        if (!fd_reg && rdata == opv_reg)
                        begin
                            fd_next = 1'b1;
                        end
                        if (i_reg + 1'b1 == occ_reg)
                        begin
                            if (fd_reg || rdata == opv_reg)
                            begin
                                occ_next = occ_reg - 1'b1;
                            end
                            else
                            begin
                                st_next = ole_pkg::ST_NOTFOUND;
                            end
                            state_next = S_FIN;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                    ole_pkg::KIND_SEARCH:
                    begin
                        if (rdata == opv_reg)
                        begin
                            fd_next = 1'b1;
                            state_next = S_FIN;
                        end
                        else if (i_reg + 1'b1 == occ_reg)
                        begin
                            st_next = ole_pkg::ST_NOTFOUND;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                    ole_pkg::KIND_SORT:
                    begin
                        key_next = rdata;
                        j_next = i_reg;
                        state_next = S_SRD;
                    end
                    ole_pkg::KIND_REVERSE:
                    begin
                        tmp_next = rdata;
                        state_next = S_RD2;
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            ov_next  = 1'b1;
                            ev_next  = rdata;
                            ocnt_next = 5'(occ_reg);
                            ls_next  = (j_reg + 1'b1 == occ_reg) ||
                                       (j_reg == CW'(ole_pkg::MaxOut - 1));
                            j_next   = j_reg + 1'b1;
                            if ((j_reg + 1'b1 == occ_reg) ||
                                (j_reg == CW'(ole_pkg::MaxOut - 1)))
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                i_next = (kind_reg == ole_pkg::KIND_DUMP_BWD) ?
                                         i_reg - 1'b1 : i_reg + 1'b1;
                                state_next = S_RD;
                            end
                        end
                    end
                endcase
            end
            S_RD2:
            begin
                raddr = j_reg[IW-1:0];
                state_next = S_EXEC2;
            end
            S_EXEC2:
            begin
                wr.we    = 1'b1;
                wr.waddr = i_reg[IW-1:0];
                wr.wdata = rdata;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                wr.we    = 1'b1;
                wr.waddr = j_reg[IW-1:0];
                wr.wdata = tmp_reg;
                if (i_reg + 1'b1 >= j_reg - 1'b1)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    j_next = j_reg - 1'b1;
                    state_next = S_RD;
                end
            end
            S_SRD:
            begin
                raddr = IW'(j_reg - 1'b1);
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                wr.we = 1'b1;
                wr.waddr = j_reg[IW-1:0];
                if ($signed(rdata) > $signed(key_reg))
                begin
                    wr.wdata = rdata;
                    j_next = j_reg - 1'b1;
                    if (j_reg == CW'(1))
                    begin
                        wr.we = 1'b1;
                        state_next = S_WR2;
                    end
                    else
                    begin
                        state_next = S_SRD;
                    end
                end
                else
                begin
                    wr.wdata = key_reg;
                    if (i_reg + 1'b1 == occ_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_WR2:
            begin
                wr.we = 1'b1;
                wr.waddr = '0;
                if (kind_reg == ole_pkg::KIND_INS_HEAD)
                begin
                    wr.wdata = opv_reg;
                    occ_next = occ_reg + 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    wr.wdata = key_reg;
                    if (i_reg + 1'b1 == occ_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    ls_next   = 1'b1;
                    ev_next   = '0;
                    ocnt_next = 5'(occ_reg);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        opv_reg  <= opv_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        key_reg  <= key_next;
        tmp_reg  <= tmp_next;
        st_reg   <= st_next;
        fd_reg   <= fd_next;
        ev_reg   <= ev_next;
        ls_reg   <= ls_next;
        ocnt_reg <= ocnt_next;
    end

`include "ordered_list_engine_macros.svh"

    `OLE_ASSERT_IMPL(a_occ_range, clk, rst_n, 1'b1, occ_reg <= CW'(ole_pkg::Depth))
    `OLE_ASSERT_NEXT(a_full_keeps, clk, rst_n,
        in_valid && in_ready && !kind[2] && !kind[1] && occ_reg == CW'(ole_pkg::Depth),
        occ_reg == CW'(ole_pkg::Depth))
    `OLE_ASSERT_IMPL(a_busy_not_ready, clk, rst_n, state_reg != S_IDLE, !in_ready)

endmodule

FILE: tb/sv/ordered_list_engine_tb.sv
// Testbench for ordered_list_engine: directed table then random list operations,
// every result checked against a predictor or a typed row. Depends on ole_pkg.
module ordered_list_engine_tb;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] entry_value;
        logic        last;
        logic [4:0]  entry_count;
    } result_t;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] operand;
        logic        typed;
        result_t     res;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  kind = ole_pkg::KIND_SEARCH;
    logic signed [31:0] operand_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic        found;
    logic signed [31:0] entry_value;
    logic        last;
    logic [4:0]  entry_count;

    logic [31:0] list_q[$];
    result_t     expected_q[$];
    int          mismatches = 0;
    int          words_out = 0;
    int          cycles = 0;
    int          send_idle = 14;
    int          recv_idle = 47;
    bit          hold_off = 1'b0;
    int          hold_cycles = 0;

    always #2 clk = ~clk;

    ordered_list_engine i_dut (.*);

    function automatic result_t mk(logic [1:0] s, logic f, logic [31:0] v, logic l);
        result_t r;
        r.status = s;
        r.found = f;
        r.entry_value = v;
        r.last = l;
        r.entry_count = 5'(list_q.size());
        return r;
    endfunction

    // Applies one operation to the list copy and queues the words it yields.
    function automatic void apply_list_op(logic [2:0] k, logic [31:0] v);
        int pos;
        int n;
        logic [31:0] t;
        pos = -1;
        case (k)
            ole_pkg::KIND_INS_HEAD, ole_pkg::KIND_INS_TAIL:
                if (list_q.size() >= ole_pkg::Depth)
                    expected_q.push_back(mk(ole_pkg::ST_FULL, 1'b0, '0, 1'b1));
                else
                begin
                    if (k == ole_pkg::KIND_INS_HEAD)
                        list_q.push_front(v);
                    else
                        list_q.push_back(v);
                    expected_q.push_back(mk(ole_pkg::ST_OK, 1'b0, '0, 1'b1));
                end
            ole_pkg::KIND_DELETE, ole_pkg::KIND_SEARCH:
            begin
                foreach (list_q[i])
                    if (pos < 0 && list_q[i] == v)
                        pos = i;
                if (pos < 0)
                    expected_q.push_back(mk(ole_pkg::ST_NOTFOUND, 1'b0, '0, 1'b1));
                else
                begin
                    if (k == ole_pkg::KIND_DELETE)
                        list_q.delete(pos);
                    expected_q.push_back(mk(ole_pkg::ST_OK, 1'b1, '0, 1'b1));
                end
            end
            ole_pkg::KIND_SORT:
            begin
                for (int i = 1; i < list_q.size(); i++)
                    for (int j = i; j > 0 && $signed(list_q[j-1]) > $signed(list_q[j]); j--)
                    begin
                        t = list_q[j];
                        list_q[j] = list_q[j-1];
                        list_q[j-1] = t;
                    end
                expected_q.push_back(mk(ole_pkg::ST_OK, 1'b0, '0, 1'b1));
            end
            ole_pkg::KIND_REVERSE:
            begin
                list_q.reverse();
                expected_q.push_back(mk(ole_pkg::ST_OK, 1'b0, '0, 1'b1));
            end
            default:
            begin
                n = list_q.size() < ole_pkg::MaxOut ? list_q.size() : ole_pkg::MaxOut;
                if (n == 0)
                    expected_q.push_back(mk(ole_pkg::ST_EMPTY, 1'b0, '0, 1'b1));
                for (int i = 0; i < n; i++)
                    expected_q.push_back(mk(ole_pkg::ST_OK, 1'b0,
                        k == ole_pkg::KIND_DUMP_FWD ? list_q[i]
                                                    : list_q[list_q.size()-1-i],
                        i == n - 1));
            end
        endcase
    endfunction

    task automatic send_word(logic [2:0] k, logic [31:0] v);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        kind <= k;
        operand_value <= v;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_list_op(k, v);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return (list_q.size() != 0) ? list_q[$urandom_range(list_q.size()-1)]
                                           : $urandom;
            3: return 32'($urandom_range(7));
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("timeout with %0d words outstanding", expected_q.size());
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_off)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end
        else
            out_ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end

    always @(posedge clk)
    begin
        result_t act;
        result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            act = '{status, found, entry_value, last, entry_count};
            words_out <= words_out + 1;
            if (expected_q.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected word %h", act);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (act !== exp_r)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display({"mismatch: expected st=%0d f=%0d v=%h l=%0d n=%0d,",
                                  " got st=%0d f=%0d v=%h l=%0d n=%0d"},
                            exp_r.status, exp_r.found, exp_r.entry_value, exp_r.last,
                            exp_r.entry_count, act.status, act.found, act.entry_value,
                            act.last, act.entry_count);
                end
            end
        end
    end

    initial
    begin
        row_t rows[$];
        row_t r;
        logic [2:0] k;
        int x;
        // after reset: empty cases with known answers, then a short mixed sequence
        rows = '{
            '{ole_pkg::KIND_DUMP_FWD, 32'h0, 1'b1,
              '{ole_pkg::ST_EMPTY, 1'b0, 32'h0, 1'b1, 5'd0}},
            '{ole_pkg::KIND_DUMP_BWD, 32'h0, 1'b1,
              '{ole_pkg::ST_EMPTY, 1'b0, 32'h0, 1'b1, 5'd0}},
            '{ole_pkg::KIND_SEARCH, 32'h5, 1'b1,
              '{ole_pkg::ST_NOTFOUND, 1'b0, 32'h0, 1'b1, 5'd0}},
            '{ole_pkg::KIND_DELETE, 32'h5, 1'b1,
              '{ole_pkg::ST_NOTFOUND, 1'b0, 32'h0, 1'b1, 5'd0}},
            '{ole_pkg::KIND_SORT, 32'h0, 1'b1,
              '{ole_pkg::ST_OK, 1'b0, 32'h0, 1'b1, 5'd0}},
            '{ole_pkg::KIND_REVERSE, 32'hffff_ffff, 1'b1,
              '{ole_pkg::ST_OK, 1'b0, 32'h0, 1'b1, 5'd0}},
            '{ole_pkg::KIND_INS_HEAD, 32'h7fff_ffff, 1'b1,
              '{ole_pkg::ST_OK, 1'b0, 32'h0, 1'b1, 5'd1}},
            '{ole_pkg::KIND_SORT, 32'h0, 1'b0, '{default: '0}},
            '{ole_pkg::KIND_REVERSE, 32'h0, 1'b0, '{default: '0}},
            '{ole_pkg::KIND_DELETE, 32'h7fff_ffff, 1'b1,
              '{ole_pkg::ST_OK, 1'b1, 32'h0, 1'b1, 5'd0}},
            '{ole_pkg::KIND_INS_TAIL, 32'h8000_0000, 1'b0, '{default: '0}},
            '{ole_pkg::KIND_INS_HEAD, 32'h0000_0001, 1'b0, '{default: '0}},
            '{ole_pkg::KIND_INS_TAIL, 32'hffff_ffff, 1'b0, '{default: '0}},
            '{ole_pkg::KIND_INS_HEAD, 32'h7fff_ffff, 1'b0, '{default: '0}},
            '{ole_pkg::KIND_DUMP_FWD, 32'h0, 1'b0, '{default: '0}},
            '{ole_pkg::KIND_REVERSE, 32'h0, 1'b0, '{default: '0}},
            '{ole_pkg::KIND_DUMP_FWD, 32'h0, 1'b0, '{default: '0}},
            '{ole_pkg::KIND_SORT, 32'h0, 1'b0, '{default: '0}},
            '{ole_pkg::KIND_DUMP_BWD, 32'h0, 1'b0, '{default: '0}},
            '{ole_pkg::KIND_SEARCH, 32'hffff_ffff, 1'b0, '{default: '0}},
            '{ole_pkg::KIND_DELETE, 32'h8000_0000, 1'b0, '{default: '0}}
        };
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
        begin
            r = rows[i];
            send_word(r.kind, r.operand);
            if (r.typed)
                expected_q[expected_q.size()-1] = r.res;
        end
        // fill to full, then overflow at both ends
        while (list_q.size() < ole_pkg::Depth)
            send_word(ole_pkg::KIND_INS_TAIL, $urandom);
        send_word(ole_pkg::KIND_INS_HEAD, 32'h1234);
        send_word(ole_pkg::KIND_INS_TAIL, 32'h1234);
        // receiver holds off while a long read-out and more words are offered
        hold_off = 1'b1;
        fork
            begin
                send_word(ole_pkg::KIND_DUMP_BWD, '0);
                send_word(ole_pkg::KIND_SORT, '0);
                send_word(ole_pkg::KIND_DUMP_FWD, '0);
            end
            begin
                while (hold_cycles < 300)
                    @(posedge clk);
                hold_off = 1'b0;
            end
        join
        drain_results();
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 14 : (ph == 1) ? 47 : 0;
            recv_idle = (ph == 0) ? 47 : (ph == 1) ? 14 : 0;
            for (int n = 0; n < 30; n++)
            begin
                x = $urandom_range(99);
                if (x < 30)
                    k = list_q.size() < 12 ? ole_pkg::KIND_INS_TAIL : ole_pkg::KIND_DELETE;
                else if (x < 45)
                    k = ole_pkg::KIND_INS_HEAD;
                else
                    k = 3'($urandom_range(7));
                send_word(k, pick_value());
            end
            drain_results();
        end
        $display("covered %0d words out across all list operations, full and empty cases,",
            words_out);
        $display("output back-pressure and three idling profiles");
        if (mismatches == 0 && expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ole_pkg.sv
rtl/core/ole_ram.sv
rtl/core/ordered_list_engine.sv
tb/sv/ordered_list_engine_tb.sv
